@@ rtl/core/bpl_pkg.sv @@
// Shared types and constants of the bounded positional list unit.
`timescale 1ns / 1ps
`default_nettype none

package bpl_pkg;

  // Sized for the largest supported capacity (64 entries).
  localparam int unsigned MAX_CAPACITY = 64;
  localparam int unsigned DEF_CAPACITY = 32;
  localparam int unsigned IDX_W        = 6;   // index of one cell, 0 to 63
  localparam int unsigned CNT_W        = 7;   // element count, 0 to 64
  localparam int unsigned DATA_W       = 32;

  typedef enum logic [2:0] {
    MODE_ADD_FIRST = 3'd0,
    MODE_INSERT    = 3'd1,
    MODE_APPEND    = 3'd2,
    MODE_DEL_FIRST = 3'd3,
    MODE_DEL_POS   = 3'd4,
    MODE_DEL_LAST  = 3'd5,
    MODE_COUNT     = 3'd6,
    MODE_DUMP      = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_EMPTY  = 2'd1,
    STATUS_BADPOS = 2'd2,
    STATUS_FULL   = 2'd3
  } status_e;

  // What every cell does when the clock ticks.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,   // open a gap at idx and write the new word there
    CELL_DEL  = 2'd2,   // close the gap at idx
    CELL_ROT  = 2'd3    // rotate the held words one place toward the head
  } cell_op_e;

  typedef struct packed {
    cell_op_e                   op;
    logic [IDX_W-1:0]           idx;
    logic [CNT_W-1:0]           cnt;
    logic signed [DATA_W-1:0]   value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/bpl_cell.sv @@
// One storage cell of the list chain.
`timescale 1ns / 1ps
`default_nettype none

module bpl_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  wire logic                              clk_i,
  input  wire bpl_pkg::cell_ctrl_t               ctrl_i,
  input  wire logic signed [bpl_pkg::DATA_W-1:0] left_i,
  input  wire logic signed [bpl_pkg::DATA_W-1:0] right_i,
  input  wire logic signed [bpl_pkg::DATA_W-1:0] head_i,
  output logic signed [bpl_pkg::DATA_W-1:0]      data_o
);

  localparam logic [bpl_pkg::IDX_W-1:0] MyIdx  = bpl_pkg::IDX_W'(CellIdx);
  localparam logic [bpl_pkg::CNT_W-1:0] MyNext = bpl_pkg::CNT_W'(CellIdx + 1);

  logic signed [bpl_pkg::DATA_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      bpl_pkg::CELL_INS: begin
        if (MyIdx == ctrl_i.idx) begin
          data_d = ctrl_i.value;
        end else if (MyIdx > ctrl_i.idx) begin
          data_d = left_i;
        end
      end
      bpl_pkg::CELL_DEL: begin
        if (MyIdx >= ctrl_i.idx) begin
          data_d = right_i;
        end
      end
      bpl_pkg::CELL_ROT: begin
        // the tail takes the old head, the cells before it advance
        if (MyNext == ctrl_i.cnt) begin
          data_d = head_i;
        end else if (MyNext < ctrl_i.cnt) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

@@ rtl/core/bounded_positional_list_unit.sv @@
// Top level of the bounded positional list unit: control and chain of cells.
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake              | Fields
// --------+-----------+------------------------+--------------------------------
// in      | in        | in_valid_i / in_ready_o | mode_i, position_i, value_i
// out     | out       | out_valid_o/ out_ready_i| status_o, element_o, length_o,
//         |           |                        | last_o
//
// Every edit, count or empty dump gives a single result word, which lands in
// the output register; a successful edit shifts the cells from its index on at once.
// A dump of n elements occupies the unit from the accepting cycle on: each
// word is read from the head cell while the chain rotates, so input is held
// off until the last word has been handed to the output register.
// Reset clears the element count, the dump state and the output valid; cell
// contents are not reset. A stalled output holds every word and every rotation.

module bounded_positional_list_unit #(
  parameter int unsigned CAPACITY = bpl_pkg::DEF_CAPACITY
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [2:0]                        mode_i,
  input  wire logic [5:0]                        position_i,
  input  wire logic signed [bpl_pkg::DATA_W-1:0] value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [1:0]                             status_o,
  output logic signed [bpl_pkg::DATA_W-1:0]      element_o,
  output logic [5:0]                             length_o,
  output logic                                   last_o
);

  localparam int unsigned CW = bpl_pkg::CNT_W;
  localparam int unsigned IW = bpl_pkg::IDX_W;
  localparam logic [CW-1:0] CapCnt = CW'(CAPACITY);

  // Element count and dump progress.
  logic [CW-1:0] cnt_q, cnt_d;
  logic          dumping_q, dumping_d;
  logic [CW-1:0] dump_idx_q, dump_idx_d;

  // Output register.
  logic                              out_valid_q, out_valid_d;
  logic [1:0]                        status_q, status_d;
  logic signed [bpl_pkg::DATA_W-1:0] element_q, element_d;
  logic [5:0]                        length_q, length_d;
  logic                              last_q, last_d;

  bpl_pkg::cell_ctrl_t ctrl;

  logic signed [bpl_pkg::DATA_W-1:0] cell_data [CAPACITY];

  logic          out_free;
  logic          in_fire;
  logic [CW-1:0] pos_ext;
  logic          dump_last;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !dumping_q && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign pos_ext    = CW'(position_i);
  assign dump_last  = (dump_idx_q + 1'b1) == cnt_q;

  always_comb begin
    cnt_d       = cnt_q;
    dumping_d   = dumping_q;
    dump_idx_d  = dump_idx_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    element_d   = element_q;
    length_d    = length_q;
    last_d      = last_q;
    ctrl.op     = bpl_pkg::CELL_HOLD;
    ctrl.idx    = '0;
    ctrl.cnt    = cnt_q;
    ctrl.value  = value_i;

    // Drop the word once the sink takes it.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (dumping_q) begin
      if (out_free) begin
        // Emit the head and rotate the held words by one place.
        out_valid_d = 1'b1;
        status_d    = bpl_pkg::STATUS_OK;
        element_d   = cell_data[0];
        length_d    = cnt_q[5:0];
        last_d      = dump_last;
        ctrl.op     = bpl_pkg::CELL_ROT;
        dump_idx_d  = dump_idx_q + 1'b1;
        if (dump_last) begin
          dumping_d = 1'b0;
        end
      end
    end else if (in_fire) begin
      status_d  = bpl_pkg::STATUS_OK;
      element_d = '0;
      last_d    = 1'b1;
      out_valid_d = 1'b1;
      case (mode_i)
        bpl_pkg::MODE_ADD_FIRST, bpl_pkg::MODE_INSERT, bpl_pkg::MODE_APPEND: begin
          if (cnt_q >= CapCnt) begin
            status_d = bpl_pkg::STATUS_FULL;
          end else if (mode_i == bpl_pkg::MODE_INSERT &&
                       (pos_ext == '0 || pos_ext > cnt_q + 1'b1)) begin
            status_d = bpl_pkg::STATUS_BADPOS;
          end else begin
            ctrl.op = bpl_pkg::CELL_INS;
            if (mode_i == bpl_pkg::MODE_ADD_FIRST) begin
              ctrl.idx = '0;
            end else if (mode_i == bpl_pkg::MODE_APPEND) begin
              ctrl.idx = cnt_q[IW-1:0];
            end else begin
              ctrl.idx = IW'(pos_ext - 1'b1);
            end
            cnt_d = cnt_q + 1'b1;
          end
        end
        bpl_pkg::MODE_DEL_FIRST, bpl_pkg::MODE_DEL_POS, bpl_pkg::MODE_DEL_LAST: begin
          if (cnt_q == '0) begin
            status_d = bpl_pkg::STATUS_EMPTY;
          end else if (mode_i == bpl_pkg::MODE_DEL_POS &&
                       (pos_ext == '0 || pos_ext > cnt_q)) begin
            status_d = bpl_pkg::STATUS_BADPOS;
          end else begin
            ctrl.op = bpl_pkg::CELL_DEL;
            if (mode_i == bpl_pkg::MODE_DEL_FIRST) begin
              ctrl.idx = '0;
            end else if (mode_i == bpl_pkg::MODE_DEL_LAST) begin
              ctrl.idx = IW'(cnt_q - 1'b1);
            end else begin
              ctrl.idx = IW'(pos_ext - 1'b1);
            end
            cnt_d = cnt_q - 1'b1;
          end
        end
        bpl_pkg::MODE_DUMP: begin
          if (cnt_q == '0) begin
            status_d = bpl_pkg::STATUS_EMPTY;
          end else begin
            // Start the dump; the first word is loaded once dumping_q is set.
            out_valid_d = 1'b0;
            dumping_d   = 1'b1;
            dump_idx_d  = '0;
          end
        end
        default: status_d = bpl_pkg::STATUS_OK;   // count
      endcase
      length_d = cnt_d[5:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      dumping_q   <= 1'b0;
      dump_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      dumping_q   <= dumping_d;
      dump_idx_q  <= dump_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    element_q <= element_d;
    length_q  <= length_d;
    last_q    <= last_d;
  end

  // Chain of cells; cell 0 is the head of the list.
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic signed [bpl_pkg::DATA_W-1:0] left_w, right_w;
    if (gi == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = cell_data[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_tail
      assign right_w = cell_data[gi];
    end else begin : g_body
      assign right_w = cell_data[gi+1];
    end
    bpl_cell #(
      .CellIdx (gi)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[gi])
    );
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign element_o   = element_q;
  assign length_o    = length_q;
  assign last_o      = last_q;

  // Count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CapCnt)
    else $error("element count above capacity");

  // A dump is only under way on a non-empty list.
  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dumping_q |-> (cnt_q != '0 && dump_idx_q < cnt_q))
    else $error("dump running past the held elements");

  // An insert grows the list by exactly one.
  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && ctrl.op == bpl_pkg::CELL_INS) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("insert did not grow the list by one");

  // A delete shrinks the list by exactly one.
  a_del_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && ctrl.op == bpl_pkg::CELL_DEL) |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("delete did not shrink the list by one");

  // The final dump word ends the dump.
  a_dump_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dumping_q && out_free && dump_last) |=> (!dumping_q && out_valid_q && last_q))
    else $error("dump did not end on its last word");

endmodule

`default_nettype wire

@@ verif/bounded_positional_list_unit_test.sv @@
// Self-checking testbench of the bounded positional list unit.
`timescale 1ns / 1ps

module bounded_positional_list_unit_test;

  localparam int unsigned CAP    = bpl_pkg::DEF_CAPACITY;
  localparam int unsigned N_DIR  = 20;
  localparam int unsigned N_RAND = 24;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] element;
    logic [5:0]  length;
    logic        last;
  } result_t;

  typedef struct {
    logic [2:0]  mode;
    logic [5:0]  pos;
    logic [31:0] value;
    bit          typed;    // expected word given below instead of predicted
    logic [1:0]  status;
    logic [5:0]  length;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  mode_i;
  logic [5:0]  position_i;
  logic [31:0] value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [31:0] element_o;
  logic [5:0]  length_o;
  logic        last_o;

  logic [31:0] list_model[$];   // predicted contents, head first
  result_t     pending_q[$];    // result words still to arrive
  result_t     fresh_q[$];      // words caused by the latest accepted item
  dir_row_t    dir_tab[N_DIR];
  int unsigned tx_pct;
  int unsigned rx_pct;
  int          err_cnt;

  bounded_positional_list_unit #(
    .CAPACITY(CAP)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .position_i (position_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .element_o  (element_o),
    .length_o   (length_o),
    .last_o     (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("bounded_positional_list_unit_test failed");
    $finish;
  end

  // Apply one operation to the list model and collect the words it causes.
  task automatic apply_list_op(input logic [2:0] m, input logic [5:0] p,
                               input logic [31:0] v);
    int      n;
    bit      dumped;
    result_t r;
    n = list_model.size();
    dumped = 1'b0;
    fresh_q.delete();
    r.status = bpl_pkg::STATUS_OK;
    case (m)
      bpl_pkg::MODE_ADD_FIRST, bpl_pkg::MODE_INSERT, bpl_pkg::MODE_APPEND: begin
        if (n >= CAP) r.status = bpl_pkg::STATUS_FULL;
        else if (m == bpl_pkg::MODE_ADD_FIRST) list_model.push_front(v);
        else if (m == bpl_pkg::MODE_APPEND) list_model.push_back(v);
        else if (p < 1 || p > n + 1) r.status = bpl_pkg::STATUS_BADPOS;
        else list_model.insert(p - 1, v);
      end
      bpl_pkg::MODE_DEL_FIRST, bpl_pkg::MODE_DEL_POS, bpl_pkg::MODE_DEL_LAST: begin
        if (n == 0) r.status = bpl_pkg::STATUS_EMPTY;
        else if (m == bpl_pkg::MODE_DEL_FIRST) void'(list_model.pop_front());
        else if (m == bpl_pkg::MODE_DEL_LAST) void'(list_model.pop_back());
        else if (p < 1 || p > n) r.status = bpl_pkg::STATUS_BADPOS;
        else list_model.delete(p - 1);
      end
      bpl_pkg::MODE_COUNT: ;
      default: begin
        if (n == 0) r.status = bpl_pkg::STATUS_EMPTY;
        else begin
          dumped = 1'b1;
          for (int i = 0; i < n; i++) begin
            r.element = list_model[i];
            r.length  = 6'(n);
            r.last    = (i == n - 1);
            fresh_q.push_back(r);
          end
        end
      end
    endcase
    if (!dumped) begin
      r.element = '0;
      r.length  = 6'(list_model.size());
      r.last    = 1'b1;
      fresh_q.push_back(r);
    end
  endtask

  // Offer one input word, hold it until accepted, then predict.
  task automatic push_word(input logic [2:0] m, input logic [5:0] p,
                           input logic [31:0] v, input bit typed,
                           input logic [1:0] st, input logic [5:0] len);
    result_t r;
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    position_i <= p;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    apply_list_op(m, p, v);
    if (typed) begin
      r.status  = st;
      r.element = '0;
      r.length  = len;
      r.last    = 1'b1;
      pending_q.push_back(r);
    end else begin
      foreach (fresh_q[i]) pending_q.push_back(fresh_q[i]);
    end
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Drive the output stall and check every accepted result word.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_pct);
      if (out_valid_o && out_ready_i) begin
        if (pending_q.size() == 0) begin
          $error("unexpected result word: status %0d element %0d length %0d last %0d",
                 status_o, $signed(element_o), length_o, last_o);
          err_cnt++;
        end else begin
          want = pending_q.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            err_cnt++;
          end
          if (element_o !== want.element) begin
            $error("element: expected %0d, got %0d", $signed(want.element),
                   $signed(element_o));
            err_cnt++;
          end
          if (length_o !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, length_o);
            err_cnt++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_o);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    int          n;
    int unsigned r;
    logic [2:0]  m;
    logic [5:0]  p;

    in_valid_i  <= 1'b0;
    mode_i      <= '0;
    position_i  <= '0;
    value_i     <= '0;
    rst_ni      <= 1'b0;
    tx_pct  = 0;
    rx_pct  = 0;
    err_cnt = 0;

    // mode, position, value, typed, status, length
    dir_tab[0]  = '{bpl_pkg::MODE_COUNT, 6'd0, 32'h0000_0000, 1'b1,
                    bpl_pkg::STATUS_OK, 6'd0};
    dir_tab[1]  = '{bpl_pkg::MODE_DUMP, 6'd0, 32'h0000_0000, 1'b1,
                    bpl_pkg::STATUS_EMPTY, 6'd0};
    dir_tab[2]  = '{bpl_pkg::MODE_DEL_FIRST, 6'd0, 32'h0000_0000, 1'b1,
                    bpl_pkg::STATUS_EMPTY, 6'd0};
    dir_tab[3]  = '{bpl_pkg::MODE_DEL_POS, 6'd1, 32'h0000_0000, 1'b1,
                    bpl_pkg::STATUS_EMPTY, 6'd0};
    dir_tab[4]  = '{bpl_pkg::MODE_DEL_LAST, 6'd0, 32'h0000_0000, 1'b1,
                    bpl_pkg::STATUS_EMPTY, 6'd0};
    dir_tab[5]  = '{bpl_pkg::MODE_INSERT, 6'd0, 32'h0000_0001, 1'b1,
                    bpl_pkg::STATUS_BADPOS, 6'd0};
    dir_tab[6]  = '{bpl_pkg::MODE_INSERT, 6'd2, 32'h0000_0002, 1'b1,
                    bpl_pkg::STATUS_BADPOS, 6'd0};
    dir_tab[7]  = '{bpl_pkg::MODE_INSERT, 6'd1, 32'h7fff_ffff, 1'b1,
                    bpl_pkg::STATUS_OK, 6'd1};
    dir_tab[8]  = '{bpl_pkg::MODE_ADD_FIRST, 6'd63, 32'h8000_0000, 1'b1,
                    bpl_pkg::STATUS_OK, 6'd2};
    dir_tab[9]  = '{bpl_pkg::MODE_APPEND, 6'd0, 32'h0000_0000, 1'b1,
                    bpl_pkg::STATUS_OK, 6'd3};
    dir_tab[10] = '{bpl_pkg::MODE_APPEND, 6'd42, 32'hffff_ffff, 1'b1,
                    bpl_pkg::STATUS_OK, 6'd4};
    dir_tab[11] = '{bpl_pkg::MODE_INSERT, 6'd5, 32'h1234_5678, 1'b1,
                    bpl_pkg::STATUS_OK, 6'd5};
    dir_tab[12] = '{bpl_pkg::MODE_INSERT, 6'd63, 32'h5555_aaaa, 1'b1,
                    bpl_pkg::STATUS_BADPOS, 6'd5};
    dir_tab[13] = '{bpl_pkg::MODE_DEL_POS, 6'd0, 32'h0000_0000, 1'b1,
                    bpl_pkg::STATUS_BADPOS, 6'd5};
    dir_tab[14] = '{bpl_pkg::MODE_DEL_POS, 6'd6, 32'hffff_ffff, 1'b1,
                    bpl_pkg::STATUS_BADPOS, 6'd5};
    dir_tab[15] = '{bpl_pkg::MODE_DUMP, 6'd63, 32'hffff_ffff, 1'b0,
                    bpl_pkg::STATUS_OK, 6'd0};
    dir_tab[16] = '{bpl_pkg::MODE_DEL_POS, 6'd3, 32'h0000_0000, 1'b0,
                    bpl_pkg::STATUS_OK, 6'd0};
    dir_tab[17] = '{bpl_pkg::MODE_DEL_FIRST, 6'd0, 32'h0000_0000, 1'b0,
                    bpl_pkg::STATUS_OK, 6'd0};
    dir_tab[18] = '{bpl_pkg::MODE_DEL_LAST, 6'd0, 32'h0000_0000, 1'b0,
                    bpl_pkg::STATUS_OK, 6'd0};
    dir_tab[19] = '{bpl_pkg::MODE_DUMP, 6'd0, 32'h0000_0000, 1'b0,
                    bpl_pkg::STATUS_OK, 6'd0};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i])
      push_word(dir_tab[i].mode, dir_tab[i].pos, dir_tab[i].value, dir_tab[i].typed,
                dir_tab[i].status, dir_tab[i].length);

    for (int i = 0; i < N_RAND; i++) begin
      case ((i * 4) / N_RAND)
        0:       begin tx_pct = 0;  rx_pct = 0;  end
        1:       begin tx_pct = 53; rx_pct = 0;  end
        2:       begin tx_pct = 0;  rx_pct = 53; end
        default: begin tx_pct = 9;  rx_pct = 9;  end
      endcase

      // Fill to capacity, probe the full list, dump it, then drain it.
      if (i == N_RAND / 2) begin
        while (list_model.size() < CAP)
          push_word(bpl_pkg::MODE_APPEND, 6'($urandom), rand_value(), 1'b0,
                    bpl_pkg::STATUS_OK, 6'd0);
        push_word(bpl_pkg::MODE_ADD_FIRST, 6'd0, rand_value(), 1'b0,
                  bpl_pkg::STATUS_OK, 6'd0);
        push_word(bpl_pkg::MODE_INSERT, 6'($urandom_range(1, CAP + 1)), rand_value(),
                  1'b0, bpl_pkg::STATUS_OK, 6'd0);
        push_word(bpl_pkg::MODE_APPEND, 6'd0, rand_value(), 1'b0,
                  bpl_pkg::STATUS_OK, 6'd0);
        push_word(bpl_pkg::MODE_DUMP, 6'd0, 32'h0, 1'b0, bpl_pkg::STATUS_OK, 6'd0);
        push_word(bpl_pkg::MODE_DEL_POS, 6'(CAP), 32'h0, 1'b0,
                  bpl_pkg::STATUS_OK, 6'd0);
        push_word(bpl_pkg::MODE_INSERT, 6'(CAP), rand_value(), 1'b0,
                  bpl_pkg::STATUS_OK, 6'd0);
        while (list_model.size() > 0)
          push_word(bpl_pkg::MODE_DEL_POS, 6'($urandom_range(1, list_model.size())),
                    rand_value(), 1'b0, bpl_pkg::STATUS_OK, 6'd0);
        push_word(bpl_pkg::MODE_DEL_POS, 6'($urandom), 32'h0, 1'b0,
                  bpl_pkg::STATUS_OK, 6'd0);
      end

      n = list_model.size();
      r = $urandom_range(0, 99);
      if (r < 45)      m = 3'($urandom_range(0, 2));
      else if (r < 80) m = 3'($urandom_range(3, 5));
      else             m = 3'($urandom_range(6, 7));
      if ($urandom_range(0, 99) < 80) begin
        if (m == bpl_pkg::MODE_INSERT) p = 6'($urandom_range(1, n + 1));
        else if (n > 0)                p = 6'($urandom_range(1, n));
        else                           p = 6'd0;
      end else begin
        p = 6'($urandom_range(0, 63));
      end
      push_word(m, p, rand_value(), 1'b0, bpl_pkg::STATUS_OK, 6'd0);
    end

    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("bounded_positional_list_unit_test passed");
    end else begin
      $display("bounded_positional_list_unit_test failed");
    end
    $finish;
  end

endmodule

@@ bounded_positional_list_unit.f @@
rtl/core/bpl_pkg.sv
rtl/core/bpl_cell.sv
rtl/core/bounded_positional_list_unit.sv
verif/bounded_positional_list_unit_test.sv
